// ----- rtl/sha256_stream_hasher_defines.svh -----
// assertion macros used by the rtl files (shash_ctrl)
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// concurrent check on clk, quiet while reset is asserted
`define SHASH_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also runs during reset
`define SHASH_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/shash_pkg.sv -----
// ----------------------------------------------------------------------------
// shash_pkg
// types, round constants and helper functions for the sha-256 hasher
// ----------------------------------------------------------------------------
`default_nettype none

package shash_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned NumWin = 16;
	localparam logic [7:0]  PadByte = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_ABSORB,
		PH_PAD,
		PH_FINAL
	} phase_t;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD80,
		SRC_ZERO,
		SRC_LEN
	} src_t;

	typedef struct packed {
		logic       shift;
		src_t       src;
		logic [2:0] len_idx;
		logic       load_v;
		logic       round;
		logic [5:0] rnd;
		logic       fold;
		logic       init;
		logic [2:0] oidx;
	} cmd_t;

	localparam logic [7:0][WordW-1:0] InitH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [63:0][WordW-1:0] RoundK = {
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
	};

	function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
		big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
		big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WordW-1:0] sml_sig0(input logic [WordW-1:0] x);
		sml_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WordW-1:0] sml_sig1(input logic [WordW-1:0] x);
		sml_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/shash_ctrl.sv -----
// ----------------------------------------------------------------------------
// shash_ctrl
// sequencer for byte intake, padding, rounds and digest output
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_stream_hasher_defines.svh"

module shash_ctrl
	import shash_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic has_byte,
	input  wire logic last_byte,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [2:0] word_index,
	output logic      last_word,
	output cmd_t      cmd
);

	state_t     state_q, state_d;
	phase_t     phase_q;
	logic       fin_q;
	logic       pad_first_q;
	logic [5:0] fill_q;
	logic [5:0] rnd_q;
	logic [2:0] oidx_q;

	logic in_xfer, out_xfer, full;

	assign in_xfer  = (state_q == ST_IDLE) && in_valid;
	assign out_xfer = (state_q == ST_OUT) && !out_stall;
	assign full     = (fill_q == 6'd63);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (has_byte && full)
						state_d = ST_ROUND;
					else if (last_byte)
						state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (full)
					state_d = ST_ROUND;
				else if (fill_q == 6'd55)
					state_d = ST_LEN;
			end
			ST_LEN: begin
				if (full)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == 6'd63)
					state_d = ST_FOLD;
			end
			ST_FOLD: begin
				unique case (phase_q)
					PH_ABSORB: state_d = fin_q ? ST_PAD : ST_IDLE;
					PH_PAD:    state_d = ST_PAD;
					PH_FINAL:  state_d = ST_OUT;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_OUT: begin
				if (out_xfer && oidx_q == 3'd7)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		cmd         = '0;
		cmd.src     = SRC_DATA;
		cmd.len_idx = fill_q[2:0];
		cmd.rnd     = rnd_q;
		cmd.oidx    = oidx_q;
		in_stall    = (state_q != ST_IDLE);
		out_valid   = (state_q == ST_OUT);
		word_index  = oidx_q;
		last_word   = (oidx_q == 3'd7);
		unique case (state_q)
			ST_IDLE: begin
				cmd.shift  = in_xfer && has_byte;
				cmd.load_v = in_xfer && has_byte && full;
			end
			ST_PAD: begin
				cmd.shift  = 1'b1;
				cmd.src    = pad_first_q ? SRC_PAD80 : SRC_ZERO;
				cmd.load_v = full;
			end
			ST_LEN: begin
				cmd.shift  = 1'b1;
				cmd.src    = SRC_LEN;
				cmd.load_v = full;
			end
			ST_ROUND: cmd.round = 1'b1;
			ST_FOLD:  cmd.fold  = 1'b1;
			ST_OUT:   cmd.init  = out_xfer && (oidx_q == 3'd7);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_ABSORB;
			fin_q       <= 1'b0;
			pad_first_q <= 1'b0;
			fill_q      <= '0;
			rnd_q       <= '0;
			oidx_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.shift)
				fill_q <= fill_q + 6'd1;
			if (in_xfer) begin
				fin_q <= last_byte;
				if (last_byte)
					pad_first_q <= 1'b1;
			end
			if (state_q == ST_PAD)
				pad_first_q <= 1'b0;
			if (cmd.load_v) begin
				unique case (state_q)
					ST_PAD:  phase_q <= PH_PAD;
					ST_LEN:  phase_q <= PH_FINAL;
					default: phase_q <= PH_ABSORB;
				endcase
			end
			if (cmd.round)
				rnd_q <= rnd_q + 6'd1;
			if (out_xfer)
				oidx_q <= oidx_q + 3'd1;
		end
	end

	`SHASH_CHECK(a_rnd_only_in_round, (rnd_q != 6'd0) |-> (state_q == ST_ROUND), "round count off")
	`SHASH_CHECK(a_len_at_tail, (state_q == ST_LEN) |-> (fill_q[5:3] == 3'd7), "length misplaced")
	`SHASH_CHECK(a_done_to_idle, (out_xfer && oidx_q == 3'd7) |=> (state_q == ST_IDLE && fill_q == 6'd0), "bad finish")

endmodule

`default_nettype wire

// ----- rtl/shash_dp.sv -----
// ----------------------------------------------------------------------------
// shash_dp
// block window, bit count, round logic and chaining words
// ----------------------------------------------------------------------------
`default_nettype none

module shash_dp
	import shash_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire logic [7:0]  data_byte,
	output logic [WordW-1:0] digest_word
);

	logic [NumWin-1:0][WordW-1:0] win_q;
	logic [7:0][WordW-1:0]        h_q;
	logic [7:0][WordW-1:0]        v_q;
	logic [63:0]                  bits_q;

	logic [7:0]       in_b;
	logic [5:0]       lsh;
	logic [WordW-1:0] w_new, t1, t2;

	assign lsh = {3'd7 - cmd.len_idx, 3'b000};

	always_comb begin
		unique case (cmd.src)
			SRC_DATA:  in_b = data_byte;
			SRC_PAD80: in_b = PadByte;
			SRC_ZERO:  in_b = 8'h00;
			SRC_LEN:   in_b = bits_q[lsh +: 8];
			default:   in_b = 8'h00;
		endcase
	end

	assign w_new = sml_sig1(win_q[14]) + win_q[9] + sml_sig0(win_q[1]) + win_q[0];
	assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ RoundK[cmd.rnd] + win_q[0];
	assign t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign digest_word = h_q[cmd.oidx];

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < NumWin - 1; i++)
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			win_q[NumWin-1] <= {win_q[NumWin-1][23:0], in_b};
		end else if (cmd.round) begin
			for (int i = 0; i < NumWin - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[NumWin-1] <= w_new;
		end
		if (cmd.load_v)
			v_q <= h_q;
		else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= InitH;
			bits_q <= '0;
		end else begin
			if (cmd.init) begin
				h_q    <= InitH;
				bits_q <= '0;
			end else begin
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
				end
				if (cmd.shift && cmd.src == SRC_DATA)
					bits_q <= bits_q + 64'd8;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-stream sha-256: absorbs bytes, pads on last, emits eight digest words
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | data_byte, has_byte, last_byte
//  out     | output    | out_valid / out_stall| digest_word, word_index, last_word
//
//  a byte transfer is taken whenever the hasher is idle; the 64th byte of a block
//  starts the rounds (single round unit, then one fold; the load rides the transfer)
//  finish: pad and length bytes, then rounds and fold per final block, then 8 words
//  the block buffer and message schedule share one 16-word shift window
//  reset restores the initial hash words and clears the counters at once
//  a stalled output holds the digest word; intake stays stalled meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher
	import shash_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	// command bundle from sequencer to datapath
	cmd_t cmd;

	shash_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.has_byte   (has_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word_index (word_index),
		.last_word  (last_word),
		.cmd        (cmd)
	);

	// window, round unit and chaining words
	shash_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.digest_word (digest_word)
	);

endmodule

`default_nettype wire

// ----- test/sha256_stream_hasher_tb.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// self-checking bench: byte messages in, predicted digest words checked out
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_tb;
	import shash_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 20000;

	// digest word as it should appear on the output channel
	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        is_last;
	} digest_exp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// predictor state
	logic [7:0]  msg_block[64];
	int unsigned msg_fill;
	logic [63:0] msg_bits;
	logic [31:0] chain_h[8];

	digest_exp_t digest_q[$];
	int unsigned error_count;
	int unsigned quiet_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	sha256_stream_hasher u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.has_byte    (has_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// standard sha-256 compression of msg_block into chain_h
	task automatic hash_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1;
		logic [31:0] t2;
		for (int r = 0; r < 16; r++)
			w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = w[r-16] + w[r-7]
				+ (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
				+ (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
		for (int i = 0; i < 8; i++)
			v[i] = chain_h[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_h[i] += v[i];
	endtask

	task automatic clear_hash_state();
		msg_fill = 0;
		msg_bits = '0;
		for (int i = 0; i < 8; i++)
			chain_h[i] = InitH[i];
	endtask

	// update the predictor for one accepted transfer, queue any digest words
	task automatic predict_digest(input logic [7:0] b, input logic hb, input logic lb);
		int unsigned pos;
		logic [63:0] total;
		if (hb) begin
			msg_block[msg_fill] = b;
			msg_fill++;
			if (msg_fill == 64) begin
				hash_block();
				msg_bits += 64'd512;
				msg_fill = 0;
			end
		end
		if (lb) begin
			pos = msg_fill;
			total = msg_bits + 64'(pos * 8);
			msg_block[pos] = PadByte;
			pos++;
			// no room for the length: an extra pad block goes first
			if (pos > 56) begin
				while (pos < 64) begin
					msg_block[pos] = 8'h00;
					pos++;
				end
				hash_block();
				pos = 0;
			end
			while (pos < 56) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			for (int k = 0; k < 8; k++)
				msg_block[56+k] = total[63-8*k -: 8];
			hash_block();
			for (int k = 0; k < 8; k++)
				digest_q.push_back('{chain_h[k], 3'(k), k == 7});
			clear_hash_state();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	// send one transfer, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic hb, input logic lb);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		has_byte  <= hb;
		last_byte <= lb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_digest(b, hb, lb);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_message(input int unsigned len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
	endtask

	// receiver stall and output check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected word", digest_word, 32'h0);
				end else begin
					if (digest_word !== digest_q[0].word)
						report_mismatch("digest_word", digest_word, digest_q[0].word);
					if (word_index !== digest_q[0].idx)
						report_mismatch("word_index", 32'(word_index), 32'(digest_q[0].idx));
					if (last_word !== digest_q[0].is_last)
						report_mismatch("last_word", 32'(last_word), 32'(digest_q[0].is_last));
					void'(digest_q.pop_front());
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// empty message, single bytes with both extremes, byte and last together
	task automatic test_directed();
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hff, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'h55, 1'b1, 1'b0);
		send_byte(8'haa, 1'b1, 1'b0);
		send_byte(8'h3c, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		go_idle();
	endtask

	// fills at 55, 56, 63 and 64 bytes: one vs two final blocks, full block
	task automatic test_block_edges();
		send_message(55);
		send_message(56);
		send_message(63);
		for (int i = 0; i < 63; i++) send_byte(8'($urandom), 1'b1, 1'b0);
		send_byte(8'hc3, 1'b1, 1'b1);
		send_message(64);
		go_idle();
	endtask

	// random messages, mostly short, noise items sprinkled in
	task automatic test_random(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
			// keep the total close to the budget
			if (len + 1 > n_items - sent)
				len = n_items - sent - 1;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(15) == 0) begin
					send_byte(8'($urandom), 1'b0, 1'b0);
					sent++;
				end
				send_byte(8'($urandom), 1'b1, 1'b0);
			end
			if ($urandom_range(1))
				send_byte(8'($urandom), 1'b1, 1'b1);
			else
				send_byte(8'($urandom), 1'b0, 1'b1);
			sent += len + 1;
		end
		go_idle();
	endtask

	task automatic wait_drain();
		while (digest_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		error_count   = 0;
		quiet_cycles  = 0;
		send_idle_pct = 13;
		recv_idle_pct = 59;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		has_byte  = 1'b0;
		last_byte = 1'b0;
		clear_hash_state();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_block_edges();
		test_random(16);
		send_idle_pct = 59;
		recv_idle_pct = 13;
		test_random(16);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(16);
		wait_drain();

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
